// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the accumulator's port checker (vna_checker).
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define VNA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Clocked assertion that also holds during reset.
`define VNA_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- sv/vna_pkg.sv -----
// ----------------------------------------------------------------------------
// vna_pkg
// Types and constants shared by the vertex normal accumulator files.
// ----------------------------------------------------------------------------
package vna_pkg;

    // Mesh size and accumulator width.
    localparam int MAX_VERTICES = 1024;
    localparam int ADDR_W       = $clog2(MAX_VERTICES);
    localparam int SUM_WIDTH    = 24;

    // Operation codes of an input beat.
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_FACE  = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    // Payload of one input beat.
    typedef struct packed {
        logic [1:0]         op;
        logic [9:0]         vertex_index;
        logic [9:0]         corner_b;
        logic [9:0]         corner_c;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } t_in_item;

    // Payload of one result beat.
    typedef struct packed {
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic               degenerate;
        logic               saturated;
    } t_out_item;

    // One entry of the position memory.
    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } t_pos;

    // One entry of the normal sum memory.
    typedef struct packed {
        logic signed [SUM_WIDTH-1:0] x;
        logic signed [SUM_WIDTH-1:0] y;
        logic signed [SUM_WIDTH-1:0] z;
    } t_sum;

endpackage

// ----- sv/vna_if.sv -----
// ----------------------------------------------------------------------------
// vna_if
// Valid/ready channels for input beats and result beats.
// ----------------------------------------------------------------------------

// Input channel.
interface vna_in_if
    import vna_pkg::*;
;
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// Result channel.
interface vna_out_if
    import vna_pkg::*;
;
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/vertex_normal_accumulator.sv -----
// A load or an ignored op goes straight to the result register; a query runs the
// one-bit-per-cycle scaling shifter, the square root and three divisions, and a face
// first forms and scales both edges and their cross product. A zero query sum or a
// degenerate face skips the root and the divisions. One item is in work at a time;
// the next is accepted in the cycle after the result register loads, later on a stall.
// Reset clears the sequencer and the result valid; both memories hold garbage until written.
// ----------------------------------------------------------------------------
// vertex_normal_accumulator
// Smooth per-vertex normals: stores positions, adds unit face normals into
// saturating per-vertex sums and returns the normalized sum on a query.
// ----------------------------------------------------------------------------
module vertex_normal_accumulator
    import vna_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    vna_in_if.sink     i_item,
    vna_out_if.source  o_result
);

    // Sequencer states.
    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_PA    = 5'd1;
    localparam logic [4:0] S_PB    = 5'd2;
    localparam logic [4:0] S_PC    = 5'd3;
    localparam logic [4:0] S_PE    = 5'd4;
    localparam logic [4:0] S_QRD   = 5'd5;
    localparam logic [4:0] S_QLD   = 5'd6;
    localparam logic [4:0] S_FMAX  = 5'd7;
    localparam logic [4:0] S_FIT   = 5'd8;
    localparam logic [4:0] S_CROSS = 5'd9;
    localparam logic [4:0] S_SQ    = 5'd10;
    localparam logic [4:0] S_SQRT  = 5'd11;
    localparam logic [4:0] S_DIV   = 5'd12;
    localparam logic [4:0] S_ARD   = 5'd13;
    localparam logic [4:0] S_AWR   = 5'd14;
    localparam logic [4:0] S_DONE  = 5'd15;

    // What the shared scaling unit is working on.
    localparam logic [1:0] PH_E1    = 2'd0;
    localparam logic [1:0] PH_E2    = 2'd1;
    localparam logic [1:0] PH_FACE  = 2'd2;
    localparam logic [1:0] PH_QUERY = 2'd3;

    localparam logic [62:0] FIT_HI    = 63'h0000_0000_4000_0000;
    localparam logic [62:0] FIT_LO    = 63'h0000_0000_2000_0000;
    localparam logic [61:0] ROOT_BIT0 = {2'b01, 60'd0};
    localparam logic [4:0]  DIV_STEPS = 5'd16;

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic signed [63:0] sx33(input logic signed [32:0] v);
        return {{31{v[32]}}, v};
    endfunction

    function automatic logic signed [63:0] sx_sum(input logic signed [SUM_WIDTH-1:0] v);
        return {{(64 - SUM_WIDTH){v[SUM_WIDTH-1]}}, v};
    endfunction

    function automatic logic signed [32:0] sub33(input logic signed [31:0] p,
                                                 input logic signed [31:0] q);
        return {p[31], p} - {q[31], q};
    endfunction

    // Memories and their ports.
    t_pos pos_mem [MAX_VERTICES];
    t_sum sum_mem [MAX_VERTICES];
    t_pos r_pos_rd;
    t_sum r_sum_rd;

    logic              pos_we, pos_re, sum_we, sum_re;
    logic [ADDR_W-1:0] pos_wa, pos_ra, sum_wa, sum_ra;
    t_pos              pos_wd;
    t_sum              sum_wd;

    // Control and datapath registers.
    logic [4:0]  r_state, n_state;
    logic [1:0]  r_phase;
    logic [2:0]  r_cnt;
    logic [4:0]  r_dcnt;
    logic [ADDR_W-1:0] r_a, r_b, r_c;
    t_pos        r_pa;
    logic signed [32:0] r_e1 [3];
    logic signed [32:0] r_e2 [3];
    logic signed [63:0] r_v [3];
    logic [62:0] r_m;
    logic signed [61:0] r_prod;
    logic [61:0] r_sq, r_x, r_root, r_bit;
    logic [32:0] r_rem;
    logic [15:0] r_num, r_q;
    logic signed [15:0] r_n [3];
    logic        r_degen, r_sat;
    logic        r_out_valid;
    t_out_item   r_out;

    logic accept, can_load, out_take;
    logic [ADDR_W-1:0] corner_addr;

    // Handshakes.
    assign accept          = i_item.valid && i_item.ready;
    assign i_item.ready    = (r_state == S_IDLE);
    assign out_take        = r_out_valid && o_result.ready;
    assign can_load        = !r_out_valid || o_result.ready;
    assign o_result.valid  = r_out_valid;
    assign o_result.data   = r_out;

    // Corner addressed by the accumulation pass.
    always_comb begin
        case (r_cnt[1:0])
            2'd0:    corner_addr = r_a;
            2'd1:    corner_addr = r_b;
            default: corner_addr = r_c;
        endcase
    end

    // Largest magnitude of the working vector.
    logic [63:0] mg0, mg1, mg2, mg01, mg_max;
    assign mg0    = mag64(r_v[0]);
    assign mg1    = mag64(r_v[1]);
    assign mg2    = mag64(r_v[2]);
    assign mg01   = (mg0 > mg1) ? mg0 : mg1;
    assign mg_max = (mg01 > mg2) ? mg01 : mg2;

    // Scaling decisions: shift right until below 2^30; for a face or query, also left until at least 2^29.
    logic fit_grow, fit_shr, fit_shl;
    assign fit_grow = (r_phase == PH_FACE) || (r_phase == PH_QUERY);
    assign fit_shr  = (r_m >= FIT_HI);
    assign fit_shl  = !fit_shr && fit_grow && (r_m != '0) && (r_m < FIT_LO);

    // Shared multiplier for the cross product and the squares.
    logic signed [30:0] mul_a, mul_b;
    logic signed [61:0] mul_p;
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_CROSS: begin
                case (r_cnt)
                    3'd0: begin mul_a = r_e1[1][30:0]; mul_b = r_e2[2][30:0]; end
                    3'd1: begin mul_a = r_e1[2][30:0]; mul_b = r_e2[1][30:0]; end
                    3'd2: begin mul_a = r_e1[2][30:0]; mul_b = r_e2[0][30:0]; end
                    3'd3: begin mul_a = r_e1[0][30:0]; mul_b = r_e2[2][30:0]; end
                    3'd4: begin mul_a = r_e1[0][30:0]; mul_b = r_e2[1][30:0]; end
                    3'd5: begin mul_a = r_e1[1][30:0]; mul_b = r_e2[0][30:0]; end
                    default: begin mul_a = '0; mul_b = '0; end
                endcase
            end
            S_SQ: begin
                case (r_cnt)
                    3'd0: begin mul_a = r_v[0][30:0]; mul_b = r_v[0][30:0]; end
                    3'd1: begin mul_a = r_v[1][30:0]; mul_b = r_v[1][30:0]; end
                    3'd2: begin mul_a = r_v[2][30:0]; mul_b = r_v[2][30:0]; end
                    default: begin mul_a = '0; mul_b = '0; end
                endcase
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // One step of the digit-by-digit square root.
    logic [61:0] rt_try;
    logic        rt_ge;
    assign rt_try = r_root + r_bit;
    assign rt_ge  = (r_x >= rt_try);

    // Divider: round(|v| * 2^14 / len) as a 16-step restoring division.
    // A scaled component can reach a magnitude of exactly 2^30, so it keeps 31 bits.
    logic [1:0]         div_idx;
    logic signed [63:0] div_v;
    logic [63:0]        div_abs;
    logic [30:0]        div_mag;
    logic [31:0]        div_len;
    logic [44:0]        div_numer;
    logic [32:0]        div_t;
    logic               div_ge;
    logic               cur_neg;
    logic signed [15:0] div_res;

    assign div_idx = (r_state == S_SQRT) ? 2'd0 : 2'(r_cnt + 3'd1);
    always_comb begin
        case (div_idx)
            2'd0:    div_v = r_v[0];
            2'd1:    div_v = r_v[1];
            2'd2:    div_v = r_v[2];
            default: div_v = '0;
        endcase
    end
    assign div_len   = r_root[31:0];
    assign div_abs   = mag64(div_v);
    assign div_mag   = div_abs[30:0];
    assign div_numer = 45'({div_mag, 14'd0}) + 45'(div_len[31:1]);
    assign div_t     = {r_rem[31:0], r_num[15]};
    assign div_ge    = (div_t >= {1'b0, div_len});

    always_comb begin
        case (r_cnt[1:0])
            2'd0:    cur_neg = r_v[0][63];
            2'd1:    cur_neg = r_v[1][63];
            default: cur_neg = r_v[2][63];
        endcase
    end
    assign div_res = cur_neg ? 16'(16'd0 - r_q) : r_q;

    // Saturating add of the face normal into one corner sum.
    logic signed [SUM_WIDTH-1:0] acc_old [3];
    logic signed [SUM_WIDTH-1:0] acc_new [3];
    logic signed [SUM_WIDTH:0]   acc_ext [3];
    logic [2:0]                  acc_ovf;
    assign acc_old[0] = r_sum_rd.x;
    assign acc_old[1] = r_sum_rd.y;
    assign acc_old[2] = r_sum_rd.z;
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            acc_ext[i] = {acc_old[i][SUM_WIDTH-1], acc_old[i]}
                       + (SUM_WIDTH + 1)'(r_n[i]);
            acc_ovf[i] = acc_ext[i][SUM_WIDTH] != acc_ext[i][SUM_WIDTH-1];
            if (!acc_ovf[i]) begin
                acc_new[i] = acc_ext[i][SUM_WIDTH-1:0];
            end else if (acc_ext[i][SUM_WIDTH]) begin
                acc_new[i] = {1'b1, {(SUM_WIDTH - 1){1'b0}}};
            end else begin
                acc_new[i] = {1'b0, {(SUM_WIDTH - 1){1'b1}}};
            end
        end
    end

    // Memory port control.
    always_comb begin
        pos_we = accept && (i_item.data.op == OP_LOAD);
        pos_wa = ADDR_W'(i_item.data.vertex_index);
        pos_wd = {i_item.data.pos_x, i_item.data.pos_y, i_item.data.pos_z};
        pos_re = (r_state == S_PA) || (r_state == S_PB) || (r_state == S_PC);
        case (r_state)
            S_PA:    pos_ra = r_a;
            S_PB:    pos_ra = r_b;
            default: pos_ra = r_c;
        endcase
        sum_we = pos_we || (r_state == S_AWR);
        sum_wa = (r_state == S_AWR) ? corner_addr : pos_wa;
        sum_wd = (r_state == S_AWR) ? {acc_new[0], acc_new[1], acc_new[2]} : '0;
        sum_re = (r_state == S_QRD) || (r_state == S_ARD);
        sum_ra = (r_state == S_QRD) ? r_a : corner_addr;
    end

    // Position memory.
    always_ff @(posedge i_clk) begin
        if (pos_we) begin
            pos_mem[pos_wa] <= pos_wd;
        end
        if (pos_re) begin
            r_pos_rd <= pos_mem[pos_ra];
        end
    end

    // Normal sum memory.
    always_ff @(posedge i_clk) begin
        if (sum_we) begin
            sum_mem[sum_wa] <= sum_wd;
        end
        if (sum_re) begin
            r_sum_rd <= sum_mem[sum_ra];
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_item.data.op)
                        OP_FACE:  n_state = S_PA;
                        OP_QUERY: n_state = S_QRD;
                        default:  n_state = S_DONE;
                    endcase
                end
            end
            S_PA:   n_state = S_PB;
            S_PB:   n_state = S_PC;
            S_PC:   n_state = S_PE;
            S_PE:   n_state = S_FMAX;
            S_QRD:  n_state = S_QLD;
            S_QLD:  n_state = S_FMAX;
            S_FMAX: n_state = S_FIT;
            S_FIT: begin
                if (!fit_shr && !fit_shl) begin
                    case (r_phase)
                        PH_E1:   n_state = S_FMAX;
                        PH_E2:   n_state = S_CROSS;
                        PH_FACE: n_state = (r_m == '0) ? S_ARD : S_SQ;
                        default: n_state = (r_m == '0) ? S_DONE : S_SQ;
                    endcase
                end
            end
            S_CROSS: begin
                if (r_cnt == 3'd6) begin
                    n_state = S_FMAX;
                end
            end
            S_SQ: begin
                if (r_cnt == 3'd3) begin
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                if (r_bit == '0) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (r_dcnt == DIV_STEPS && r_cnt == 3'd2) begin
                    n_state = (r_phase == PH_FACE) ? S_ARD : S_DONE;
                end
            end
            S_ARD:  n_state = S_AWR;
            S_AWR:  n_state = (r_cnt == 3'd2) ? S_DONE : S_ARD;
            S_DONE: begin
                if (can_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DONE && can_load) begin
                r_out_valid <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    r_a     <= ADDR_W'(i_item.data.vertex_index);
                    r_b     <= ADDR_W'(i_item.data.corner_b);
                    r_c     <= ADDR_W'(i_item.data.corner_c);
                    r_n     <= '{default: '0};
                    r_degen <= 1'b0;
                    r_sat   <= 1'b0;
                    r_cnt   <= '0;
                    r_phase <= (i_item.data.op == OP_FACE) ? PH_E1 : PH_QUERY;
                end
            end
            S_PB: r_pa <= r_pos_rd;
            S_PC: begin
                r_e1[0] <= sub33(r_pos_rd.x, r_pa.x);
                r_e1[1] <= sub33(r_pos_rd.y, r_pa.y);
                r_e1[2] <= sub33(r_pos_rd.z, r_pa.z);
            end
            S_PE: begin
                r_e2[0] <= sub33(r_pos_rd.x, r_pa.x);
                r_e2[1] <= sub33(r_pos_rd.y, r_pa.y);
                r_e2[2] <= sub33(r_pos_rd.z, r_pa.z);
                for (int i = 0; i < 3; i++) begin
                    r_v[i] <= sx33(r_e1[i]);
                end
            end
            S_QLD: begin
                r_v[0] <= sx_sum(r_sum_rd.x);
                r_v[1] <= sx_sum(r_sum_rd.y);
                r_v[2] <= sx_sum(r_sum_rd.z);
            end
            S_FMAX: r_m <= mg_max[62:0];
            // One bit of scaling per cycle; the scaled magnitude tracks the vector.
            S_FIT: begin
                if (fit_shr) begin
                    for (int i = 0; i < 3; i++) begin
                        r_v[i] <= r_v[i] >>> 1;
                    end
                    r_m <= r_m >> 1;
                end else if (fit_shl) begin
                    for (int i = 0; i < 3; i++) begin
                        r_v[i] <= r_v[i] <<< 1;
                    end
                    r_m <= r_m << 1;
                end else begin
                    r_cnt <= '0;
                    case (r_phase)
                        PH_E1: begin
                            for (int i = 0; i < 3; i++) begin
                                r_e1[i] <= r_v[i][32:0];
                                r_v[i]  <= sx33(r_e2[i]);
                            end
                            r_phase <= PH_E2;
                        end
                        PH_E2: begin
                            for (int i = 0; i < 3; i++) begin
                                r_e2[i] <= r_v[i][32:0];
                            end
                        end
                        default: begin
                            if (r_m == '0) begin
                                r_degen <= 1'b1;
                            end
                        end
                    endcase
                end
            end
            // Cross product: one product per cycle, combined in the next cycle.
            S_CROSS: begin
                r_prod <= mul_p;
                r_cnt  <= r_cnt + 3'd1;
                case (r_cnt)
                    3'd1: r_v[0] <= 64'(r_prod);
                    3'd2: r_v[0] <= r_v[0] - 64'(r_prod);
                    3'd3: r_v[1] <= 64'(r_prod);
                    3'd4: r_v[1] <= r_v[1] - 64'(r_prod);
                    3'd5: r_v[2] <= 64'(r_prod);
                    3'd6: begin
                        r_v[2]  <= r_v[2] - 64'(r_prod);
                        r_phase <= PH_FACE;
                    end
                    default: r_v[0] <= r_v[0];
                endcase
            end
            // Sum of squares.
            S_SQ: begin
                r_prod <= mul_p;
                case (r_cnt)
                    3'd0: begin
                        r_sq  <= '0;
                        r_cnt <= r_cnt + 3'd1;
                    end
                    3'd3: begin
                        r_x    <= r_sq + 62'(r_prod);
                        r_root <= '0;
                        r_bit  <= ROOT_BIT0;
                        r_cnt  <= '0;
                    end
                    default: begin
                        r_sq  <= r_sq + 62'(r_prod);
                        r_cnt <= r_cnt + 3'd1;
                    end
                endcase
            end
            S_SQRT: begin
                if (r_bit != '0) begin
                    if (rt_ge) begin
                        r_x    <= r_x - rt_try;
                        r_root <= (r_root >> 1) + r_bit;
                    end else begin
                        r_root <= r_root >> 1;
                    end
                    r_bit <= r_bit >> 2;
                end else begin
                    r_rem  <= 33'(div_numer[44:16]);
                    r_num  <= div_numer[15:0];
                    r_q    <= '0;
                    r_dcnt <= '0;
                    r_cnt  <= '0;
                end
            end
            S_DIV: begin
                if (r_dcnt != DIV_STEPS) begin
                    r_rem  <= div_ge ? (div_t - {1'b0, div_len}) : div_t;
                    r_num  <= r_num << 1;
                    r_q    <= {r_q[14:0], div_ge};
                    r_dcnt <= r_dcnt + 5'd1;
                end else begin
                    case (r_cnt[1:0])
                        2'd0:    r_n[0] <= div_res;
                        2'd1:    r_n[1] <= div_res;
                        default: r_n[2] <= div_res;
                    endcase
                    if (r_cnt != 3'd2) begin
                        r_rem  <= 33'(div_numer[44:16]);
                        r_num  <= div_numer[15:0];
                        r_q    <= '0;
                        r_dcnt <= '0;
                        r_cnt  <= r_cnt + 3'd1;
                    end else begin
                        r_cnt <= '0;
                    end
                end
            end
            S_AWR: begin
                r_sat <= r_sat | (|acc_ovf);
                r_cnt <= r_cnt + 3'd1;
            end
            // A face beat reports only its flags; its normal went into the sums.
            S_DONE: begin
                if (can_load) begin
                    r_out.normal_x   <= (r_phase == PH_FACE) ? '0 : r_n[0];
                    r_out.normal_y   <= (r_phase == PH_FACE) ? '0 : r_n[1];
                    r_out.normal_z   <= (r_phase == PH_FACE) ? '0 : r_n[2];
                    r_out.degenerate <= r_degen;
                    r_out.saturated  <= r_sat;
                end
            end
            default: r_cnt <= r_cnt;
        endcase
    end

endmodule

// ----- sv/vna_checker.sv -----
// ----------------------------------------------------------------------------
// vna_checker
// Port-level checks on the result channel of the vertex normal accumulator.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vna_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic signed [15:0] i_nx,
    input logic signed [15:0] i_ny,
    input logic signed [15:0] i_nz,
    input logic               i_degen,
    input logic               i_sat
);

    // Every component lies within unit length in Q1.14.
    logic in_range;
    assign in_range = (i_nx >= -16'sd16384) && (i_nx <= 16'sd16384)
                   && (i_ny >= -16'sd16384) && (i_ny <= 16'sd16384)
                   && (i_nz >= -16'sd16384) && (i_nz <= 16'sd16384);

    // A result beat waits until it is taken.
    `VNA_ASSERT(a_hold, i_out_valid && !i_out_ready |=> i_out_valid, "result dropped")

    // Normals stay within unit length in Q1.14.
    `VNA_ASSERT(a_range, i_out_valid |-> in_range, "normal out of range")

    // A degenerate result carries a zero normal.
    `VNA_ASSERT(a_degen, i_out_valid && i_degen |-> (i_nx == 16'sd0 && i_ny == 16'sd0 && i_nz == 16'sd0), "degenerate normal not zero")

    // Saturation only comes from a face beat: no normal and no degenerate flag.
    `VNA_ASSERT(a_sat, i_out_valid && i_sat |-> (!i_degen && i_nx == 16'sd0 && i_ny == 16'sd0 && i_nz == 16'sd0), "saturated on a non-face beat")

    // Reset empties the result register.
    `VNA_ASSERT_RST(a_reset, !i_rst_n |=> !i_out_valid, "result valid after reset")

endmodule

bind vertex_normal_accumulator vna_checker u_vna_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_nx        (o_result.data.normal_x),
    .i_ny        (o_result.data.normal_y),
    .i_nz        (o_result.data.normal_z),
    .i_degen     (o_result.data.degenerate),
    .i_sat       (o_result.data.saturated)
);

// ----- tb/vertex_normal_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_normal_checker
// Watches the item and result channels of the vertex normal accumulator,
// predicts every result beat from its own copy of the mesh state and
// compares each result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module vertex_normal_checker
    import vna_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    vna_in_if.sink    i_item_mon,
    vna_out_if.sink   i_result_mon,
    output int        o_fail_count,
    output int        o_pending
);

    // Mirror of the block's memories.
    t_pos      pos_mem [MAX_VERTICES];
    t_sum      sum_mem [MAX_VERTICES];
    t_out_item normal_queue [$];

    assign o_pending = normal_queue.size();

    function automatic longint unsigned abs64(longint v);
        return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    // Arithmetic shift right rounding toward minus infinity.
    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    // Scales so the largest magnitude is at most 2^30; with grow at least 2^29.
    function automatic void scale_vec(ref longint v[3], input bit grow);
        longint unsigned m;
        int n;
        m = 0;
        for (int i = 0; i < 3; i++)
            if (abs64(v[i]) > m) m = abs64(v[i]);
        if (m == 0) return;
        n = 0;
        while (m != 0) begin
            n++;
            m = m >> 1;
        end
        if (n > 30) begin
            for (int i = 0; i < 3; i++) v[i] = floor_shift(v[i], n - 30);
        end else if (grow && n < 30) begin
            for (int i = 0; i < 3; i++) v[i] = v[i] <<< (30 - n);
        end
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Returns 1 for a zero-length vector; unit holds the Q1.14 result.
    function automatic bit unit_vector(ref longint v[3], ref longint unit[3]);
        longint unsigned sq, len, q;
        scale_vec(v, 1'b1);
        for (int i = 0; i < 3; i++) unit[i] = 0;
        if (v[0] == 0 && v[1] == 0 && v[2] == 0) return 1'b1;
        sq = longint'(v[0] * v[0]) + longint'(v[1] * v[1]) + longint'(v[2] * v[2]);
        len = int_sqrt(sq);
        for (int i = 0; i < 3; i++) begin
            q = (abs64(v[i]) * 16384 + len / 2) / len;
            unit[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
        end
        return 1'b0;
    endfunction

    function automatic longint sum_field(t_sum s, int i);
        case (i)
            0:       return longint'(s.x);
            1:       return longint'(s.y);
            default: return longint'(s.z);
        endcase
    endfunction

    function automatic longint pos_field(t_pos p, int i);
        case (i)
            0:       return longint'(p.x);
            1:       return longint'(p.y);
            default: return longint'(p.z);
        endcase
    endfunction

    // Applies one item to the mirror and returns the expected result beat.
    function automatic t_out_item predict_normal(t_in_item it);
        t_out_item r;
        longint e1[3], e2[3], cr[3], fn[3], v[3];
        longint hi, lo, s;
        logic [9:0] corner[3];
        r = '0;
        for (int i = 0; i < 3; i++) fn[i] = 0;
        hi = (64'sd1 <<< (SUM_WIDTH - 1)) - 1;
        lo = -hi - 1;
        case (it.op)
            OP_LOAD: begin
                if (it.vertex_index < MAX_VERTICES) begin
                    pos_mem[it.vertex_index] = '{it.pos_x, it.pos_y, it.pos_z};
                    sum_mem[it.vertex_index] = '0;
                end
            end
            OP_FACE: begin
                corner[0] = it.vertex_index;
                corner[1] = it.corner_b;
                corner[2] = it.corner_c;
                if (corner[0] < MAX_VERTICES && corner[1] < MAX_VERTICES &&
                        corner[2] < MAX_VERTICES) begin
                    for (int i = 0; i < 3; i++) begin
                        e1[i] = pos_field(pos_mem[corner[1]], i) - pos_field(pos_mem[corner[0]], i);
                        e2[i] = pos_field(pos_mem[corner[2]], i) - pos_field(pos_mem[corner[0]], i);
                    end
                    scale_vec(e1, 1'b0);
                    scale_vec(e2, 1'b0);
                    cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
                    cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
                    cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
                    r.degenerate = unit_vector(cr, fn);
                    for (int k = 0; k < 3; k++) begin
                        for (int i = 0; i < 3; i++) begin
                            s = sum_field(sum_mem[corner[k]], i) + fn[i];
                            if (s > hi) begin
                                s = hi;
                                r.saturated = 1'b1;
                            end
                            if (s < lo) begin
                                s = lo;
                                r.saturated = 1'b1;
                            end
                            case (i)
                                0:       sum_mem[corner[k]].x = s[SUM_WIDTH-1:0];
                                1:       sum_mem[corner[k]].y = s[SUM_WIDTH-1:0];
                                default: sum_mem[corner[k]].z = s[SUM_WIDTH-1:0];
                            endcase
                        end
                    end
                end
            end
            OP_QUERY: begin
                if (it.vertex_index < MAX_VERTICES) begin
                    for (int i = 0; i < 3; i++) v[i] = sum_field(sum_mem[it.vertex_index], i);
                    r.degenerate = unit_vector(v, fn);
                    r.normal_x = fn[0][15:0];
                    r.normal_y = fn[1][15:0];
                    r.normal_z = fn[2][15:0];
                end else begin
                    r.degenerate = 1'b1;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        o_fail_count++;
    endtask

    // Predict on every accepted item beat, compare on every result beat.
    always @(posedge i_clk) begin
        t_out_item want, got;
        if (!i_rst_n) begin
            o_fail_count <= o_fail_count;
        end else begin
            if (i_item_mon.valid && i_item_mon.ready)
                normal_queue.push_back(predict_normal(i_item_mon.data));
            if (i_result_mon.valid && i_result_mon.ready) begin
                got = i_result_mon.data;
                if (normal_queue.size() == 0) begin
                    report_mismatch("result beat with no prediction waiting");
                end else begin
                    want = normal_queue.pop_front();
                    if (got.normal_x !== want.normal_x)
                        report_mismatch($sformatf("normal_x got %0d want %0d",
                            got.normal_x, want.normal_x));
                    if (got.normal_y !== want.normal_y)
                        report_mismatch($sformatf("normal_y got %0d want %0d",
                            got.normal_y, want.normal_y));
                    if (got.normal_z !== want.normal_z)
                        report_mismatch($sformatf("normal_z got %0d want %0d",
                            got.normal_z, want.normal_z));
                    if (got.degenerate !== want.degenerate)
                        report_mismatch($sformatf("degenerate got %b want %b",
                            got.degenerate, want.degenerate));
                    if (got.saturated !== want.saturated)
                        report_mismatch($sformatf("saturated got %b want %b",
                            got.saturated, want.saturated));
                end
            end
        end
    end

    initial o_fail_count = 0;

endmodule

// ----- tb/vertex_normal_accumulator_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_normal_accumulator_tb
// Drives loads, faces, queries and ignored ops into the accumulator with random gaps and
// result stalls, lets the checker judge every result beat, and prints the
// verdict.
// ----------------------------------------------------------------------------
module vertex_normal_accumulator_tb;
    import vna_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int N_SMALL = 16;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   idle_cycles;
    int   send_idle_pct;
    int   recv_stall_pct;
    bit   hold_off;
    bit   loaded [MAX_VERTICES];
    int   loaded_list [$];

    vna_in_if  item_ch ();
    vna_out_if result_ch ();

    vertex_normal_accumulator DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch.sink),
        .o_result (result_ch.source)
    );

    vertex_normal_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_mon   (item_ch.sink),
        .i_result_mon (result_ch.sink),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // Receiver: random stalls, plus a long hold-off on request.
    always @(posedge i_clk) begin
        if (!i_rst_n)
            result_ch.ready <= 1'b0;
        else
            result_ch.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog on cycles without any accepted beat.
    always @(posedge i_clk) begin
        if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Offers one beat after a random gap and waits for its acceptance. Valid
    // stays high when the next beat follows at once; a gap drops it.
    task automatic send_item(t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            item_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_ch.data  <= it;
        item_ch.valid <= 1'b1;
        @(posedge i_clk);
        while (!item_ch.ready) @(posedge i_clk);
        if (it.op == OP_LOAD && it.vertex_index < MAX_VERTICES &&
                !loaded[it.vertex_index]) begin
            loaded[it.vertex_index] = 1'b1;
            loaded_list.push_back(it.vertex_index);
        end
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(3))
            0:       return $urandom;
            1:       return $urandom_range(1, 0) ? 32'h7fffffff : 32'h80000000;
            default: return 32'(int'($urandom_range(20 << 16)) - (10 << 16));
        endcase
    endfunction

    function automatic t_in_item make_load(int idx);
        t_in_item it;
        it = '0;
        it.op = OP_LOAD;
        it.vertex_index = 10'(idx);
        it.pos_x = rand_coord();
        it.pos_y = rand_coord();
        it.pos_z = rand_coord();
        return it;
    endfunction

    function automatic int pick_loaded();
        return loaded_list[$urandom_range(loaded_list.size() - 1)];
    endfunction

    function automatic t_in_item make_face(int a, int b, int c);
        t_in_item it;
        it = '0;
        it.op = OP_FACE;
        it.vertex_index = 10'(a);
        it.corner_b = 10'(b);
        it.corner_c = 10'(c);
        it.pos_x = $urandom;
        return it;
    endfunction

    function automatic t_in_item make_query(int idx);
        t_in_item it;
        it = '0;
        it.op = OP_QUERY;
        it.vertex_index = 10'(idx);
        it.pos_y = $urandom;
        return it;
    endfunction

    // Random mix: mostly loads, faces and queries over loaded vertices.
    function automatic t_in_item random_item();
        t_in_item it;
        int r;
        r = $urandom_range(99);
        if (loaded_list.size() < 3 || r < 20)
            return make_load($urandom_range(1) ? $urandom_range(N_SMALL - 1)
                                               : $urandom_range(MAX_VERTICES - 1));
        if (r < 60)
            return make_face(pick_loaded(), pick_loaded(), pick_loaded());
        if (r < 92)
            return make_query(pick_loaded());
        it = make_query(pick_loaded());
        it.op = 2'd3;
        it.corner_b = 10'($urandom);
        it.corner_c = 10'($urandom);
        return it;
    endfunction

    initial begin
        t_in_item it;
        hold_off       = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        idle_cycles    = 0;
        item_ch.valid  = 1'b0;
        item_ch.data   = '0;
        result_ch.ready = 1'b0;
        i_rst_n = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes, every operation, degenerate and saturating faces.
        send_item(make_load(0));
        it = make_load(1);
        it.pos_x = 32'h7fffffff; it.pos_y = 32'h80000000; it.pos_z = 32'h7fffffff;
        send_item(it);
        it = make_load(1023);
        it.pos_x = 32'h80000000; it.pos_y = 32'h7fffffff; it.pos_z = 32'h00000000;
        send_item(it);
        it = make_load(2);
        it.pos_x = 32'h00010000; it.pos_y = 0; it.pos_z = 0;
        send_item(it);
        it = make_load(3);
        it.pos_x = 0; it.pos_y = 32'h00010000; it.pos_z = 0;
        send_item(it);
        send_item(make_face(0, 1, 1023));
        send_item(make_face(1023, 1, 0));
        send_item(make_face(2, 2, 3));
        send_item(make_face(0, 0, 0));
        send_item(make_query(0));
        send_item(make_query(1023));
        send_item(make_query(1));
        send_item(make_load(4));
        send_item(make_query(4));
        it = make_query(5);
        it.op = 2'd3;
        it.vertex_index = 10'h3ff; it.corner_b = 10'h3ff; it.corner_c = 10'h3ff;
        it.pos_x = '1; it.pos_y = '1; it.pos_z = '1;
        send_item(it);
        // Pile unit normals onto three vertices until their sums clip; each face
        // adds 16384 to z, so the sums clip from the 512th face on.
        it = make_load(5);
        it.pos_x = 0; it.pos_y = 0; it.pos_z = 0;
        send_item(it);
        it = make_load(6);
        it.pos_x = 32'h00010000; it.pos_y = 0; it.pos_z = 0;
        send_item(it);
        it = make_load(7);
        it.pos_x = 0; it.pos_y = 32'h00010000; it.pos_z = 0;
        send_item(it);
        for (int i = 0; i < 515; i++) send_item(make_face(5, 6, 7));
        send_item(make_query(5));

        // Random phases with different idling mixes.
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 56; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 56; end
                3:       begin send_idle_pct = 37; recv_stall_pct = 37; end
                default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            endcase
            if (ph == 4) begin
                // Long receiver hold-off while items keep coming.
                hold_off = 1'b1;
                fork
                    begin
                        repeat (600) @(posedge i_clk);
                        hold_off = 1'b0;
                    end
                    for (int i = 0; i < 40; i++) send_item(random_item());
                join
            end
            for (int i = 0; i < 50; i++) send_item(random_item());
        end
        item_ch.valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+sv
sv/vna_pkg.sv
sv/vna_if.sv
sv/vertex_normal_accumulator.sv
sv/vna_checker.sv
tb/vertex_normal_checker.sv
tb/vertex_normal_accumulator_tb.sv
